// ===== design/bhts_pkg.sv =====
package bhts_pkg;

   localparam int HASH_W  = 32;
   localparam int SLOT_W  = 10;
   localparam int COUNT_W = 11;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd16;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic              lookup;
      logic [SLOT_W-1:0] slot;
      logic [HASH_W-1:0] hash;
   } cmd_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] match_index;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PROBE,
      BK_CMP,
      BK_RESULT
   } back_state_type;

endpackage

// ===== design/bhts_ram.sv =====
module bhts_ram
   #(
      parameter int WIDTH = 32,
      parameter int DEPTH = 64
   )
   (
      input  logic                             clock,
      input  logic                             wr_en,
      input  logic [$clog2(DEPTH)-1:0]         wr_addr,
      input  logic [WIDTH-1:0]                 wr_data,
      input  logic [$clog2(DEPTH)-1:0]         rd_addr,
      output logic [WIDTH-1:0]                 rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bhts_fifo.sv =====
module bhts_fifo
   #(
      parameter int WIDTH = 8,
      parameter int DEPTH = 2
   )
   (
      input  logic             clock,
      input  logic             reset,
      input  logic             wr_en,
      input  logic [WIDTH-1:0] wr_data,
      input  logic             rd_en,
      output logic [WIDTH-1:0] rd_data,
      output logic             full,
      output logic             empty
   );

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== design/bhts_front.sv =====
module bhts_front
   import bhts_pkg::*;
   #(
      parameter int MAX_ENTRIES = 1024
   )
   (
      input  logic              clock,
      input  logic              reset,
      input  logic              push,
      output logic              full,
      input  logic              opcode,
      input  logic [SLOT_W-1:0] entry_slot,
      input  logic [HASH_W-1:0] hash_value,
      input  logic              cmd_pop,
      output logic              cmd_empty,
      output cmd_type           cmd
   );

   cmd_type                 cmd_in;
   logic                    keep;
   logic                    accept;
   logic [$bits(cmd_type)-1:0] cmd_bits;

   // Drop writes that land beyond the store; lookups always pass.
   assign keep   = (opcode == OP_LOOKUP) || (32'(entry_slot) < MAX_ENTRIES);
   assign accept = push && !full;

   always_comb begin
      cmd_in.lookup = (opcode == OP_LOOKUP);
      cmd_in.slot   = entry_slot;
      cmd_in.hash   = hash_value;
   end

   bhts_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && keep),
      .wr_data (cmd_in),
      .rd_en   (cmd_pop),
      .rd_data (cmd_bits),
      .full    (full),
      .empty   (cmd_empty)
   );

   assign cmd = cmd_type'(cmd_bits);

endmodule

// ===== design/bhts_back.sv =====
module bhts_back
   import bhts_pkg::*;
   #(
      parameter int MAX_ENTRIES = 1024,
      parameter int GROUP_SIZE  = 16
   )
   (
      input  logic               clock,
      input  logic               reset,
      input  logic [COUNT_W-1:0] entry_count,
      input  logic               cmd_empty,
      input  cmd_type            cmd,
      output logic               cmd_pop,
      input  logic               rsp_pop,
      output logic               rsp_empty,
      output rsp_type            rsp
   );

   localparam int GB   = $clog2(GROUP_SIZE);
   localparam int ROWS = MAX_ENTRIES / GROUP_SIZE;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int GCW  = RW + 1;

   back_state_type     state_ff, state_in;
   logic [HASH_W-1:0]  key_ff, key_in;
   logic [GCW-1:0]     lo_ff, lo_in;
   logic [GCW-1:0]     hi_ff, hi_in;
   logic [RW-1:0]      probe_ff, probe_in;
   logic               found_ff, found_in;
   logic [SLOT_W-1:0]  index_ff, index_in;

   logic [HASH_W-1:0]  lane_data [GROUP_SIZE];
   logic [GCW-1:0]     groups;
   logic [COUNT_W-1:0] count_groups;
   logic [GCW:0]       mid_sum;
   logic [RW-1:0]      rd_row;
   logic               ram_we;
   logic [RW-1:0]      wr_row;
   logic               hit;
   logic [GB-1:0]      hit_lane;
   logic               key_above;
   logic [GCW-1:0]     next_lo, next_hi;
   logic               rsp_full;
   logic               rsp_push;
   rsp_type            rsp_in;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   // Usable groups: saturate the count at the store size, drop the ragged tail.
   assign count_groups = entry_count >> GB;
   assign groups = (32'(entry_count) >= MAX_ENTRIES) ? GCW'(ROWS) : GCW'(count_groups);

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign rd_row  = RW'(mid_sum >> 1);

   assign ram_we = (state_ff == BK_IDLE) && !cmd_empty && !cmd.lookup;
   assign wr_row = RW'(cmd.slot >> GB);

   for (genvar b = 0; b < GROUP_SIZE; b++) begin : g_bank
      bhts_ram #(
         .WIDTH (HASH_W),
         .DEPTH (ROWS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (ram_we && (cmd.slot[GB-1:0] == GB'(b))),
         .wr_addr (wr_row),
         .wr_data (cmd.hash),
         .rd_addr (rd_row),
         .rd_data (lane_data[b])
      );
   end

   // Lowest matching lane of the probed group.
   always_comb begin
      hit      = 1'b0;
      hit_lane = '0;
      for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
         if (lane_data[k] == key_ff) begin
            hit      = 1'b1;
            hit_lane = GB'(k);
         end
      end
   end

   assign key_above = (lane_data[0] < key_ff);
   assign next_lo   = GCW'(probe_ff) + 1'b1;
   assign next_hi   = GCW'(probe_ff) - 1'b1;

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      probe_in = probe_ff;
      found_in = found_ff;
      index_in = index_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd.lookup) begin
                  key_in   = cmd.hash;
                  lo_in    = '0;
                  hi_in    = groups - 1'b1;
                  found_in = 1'b0;
                  index_in = '0;
                  state_in = (groups == '0) ? BK_RESULT : BK_PROBE;
               end
            end
         end
         BK_PROBE: begin
            probe_in = rd_row;
            state_in = BK_CMP;
         end
         BK_CMP: begin
            if (hit) begin
               found_in = 1'b1;
               index_in = SLOT_W'({probe_ff, hit_lane});
               state_in = BK_RESULT;
            end else if (key_above) begin
               lo_in    = next_lo;
               state_in = (next_lo > hi_ff) ? BK_RESULT : BK_PROBE;
            end else if (probe_ff == '0) begin
               state_in = BK_RESULT;
            end else begin
               hi_in    = next_hi;
               state_in = (lo_ff > next_hi) ? BK_RESULT : BK_PROBE;
            end
         end
         BK_RESULT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      probe_ff <= probe_in;
      found_ff <= found_in;
      index_ff <= index_in;
   end

   always_comb begin
      rsp_in.found       = found_ff;
      rsp_in.match_index = index_ff;
   end

   bhts_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_in),
      .rd_en   (rsp_pop),
      .rd_data (rsp_bits),
      .full    (rsp_full),
      .empty   (rsp_empty)
   );

   assign rsp = rsp_type'(rsp_bits);

endmodule

// ===== design/blocked_hash_table_search_top.sv =====
// Channel    Handshake            Ports (beat contents)
// ---------  -------------------  ---------------------------------------------
// request    push / full          req_opcode, req_entry_slot, req_hash_value
// response   empty / pop          rsp_found, rsp_match_index (one per lookup)
// csr        csr_wr_en            csr_wr_data = entry_count, no read-back
//
// A write beat writes one bank of the group RAM.
// A lookup runs P probes, P at most log2(groups) + 1, then returns its result;
// each probe is one registered read of all GROUP_SIZE banks, then a compare.
// Reset is synchronous and clears only control state; the table is undefined
// until written and entry_count returns to 16.
// The two-entry command queue keeps taking beats while the search runs, and the
// two-entry response queue holds results while pop is low.
// GROUP_SIZE must be a power of two and divide MAX_ENTRIES.
module blocked_hash_table_search_top
   import bhts_pkg::*;
   #(
      parameter int MAX_ENTRIES = 1024,
      parameter int GROUP_SIZE  = 16
   )
   (
      input  logic               clock,
      input  logic               reset,
      // request channel
      input  logic               push,
      output logic               full,
      input  logic               req_opcode,
      input  logic [SLOT_W-1:0]  req_entry_slot,
      input  logic [HASH_W-1:0]  req_hash_value,
      // response channel
      output logic               empty,
      input  logic               pop,
      output logic               rsp_found,
      output logic [SLOT_W-1:0]  rsp_match_index,
      // configuration
      input  logic               csr_wr_en,
      input  logic [COUNT_W-1:0] csr_wr_data
   );

   logic [COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic               cmd_empty;
   logic               cmd_pop;
   cmd_type            cmd;
   rsp_type            rsp;

   // Hold entry_count until software rewrites it.
   assign entry_count_in = csr_wr_en ? csr_wr_data : entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= COUNT_RESET;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   // Front end: accept beats, drop out-of-range writes, queue the rest.
   bhts_front #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .opcode     (req_opcode),
      .entry_slot (req_entry_slot),
      .hash_value (req_hash_value),
      .cmd_pop    (cmd_pop),
      .cmd_empty  (cmd_empty),
      .cmd        (cmd)
   );

   // Back end: apply writes to the banked table, run the group search.
   bhts_back #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .GROUP_SIZE  (GROUP_SIZE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_count (entry_count_ff),
      .cmd_empty   (cmd_empty),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .rsp_pop     (pop),
      .rsp_empty   (empty),
      .rsp         (rsp)
   );

   assign rsp_found       = rsp.found;
   assign rsp_match_index = rsp.match_index;

endmodule
